### rtl/hlfr_pkg.sv
package hlfr_pkg;

    localparam int BYTE_W  = 8;
    localparam int CFG_IDX_W = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_HDR  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_HDR = 1'b1;

    typedef logic [BYTE_W-1:0] t_byte;

    typedef enum logic [2:0] {
        PH_HEAD0 = 3'd0,
        PH_HEAD1 = 3'd1,
        PH_LEN   = 3'd2,
        PH_PAYL  = 3'd3,
        PH_CSUM0 = 3'd4,
        PH_CSUM1 = 3'd5,
        PH_EMIT  = 3'd6
    } t_phase;

endpackage

### rtl/hlfr_rx_if.sv
interface hlfr_rx_if;
    logic            valid;
    logic            ready;
    hlfr_pkg::t_byte rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

### rtl/hlfr_frame_if.sv
interface hlfr_frame_if;
    logic            valid;
    logic            ready;
    hlfr_pkg::t_byte frame_byte;
    logic            frame_last;

    modport source (output valid, output frame_byte, output frame_last, input ready);
    modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

### rtl/header_length_frame_receiver_core.sv
// Frame receiver: hunts a two-byte header and a length byte in a byte stream,
// stores length, payload and two checksum bytes, then plays the frame back.
// i_rx (sink): one received byte per transaction, accepted on valid && ready.
// o_frame (source): one stored byte per transaction, frame_last on the final
// byte. Frames are length + 2 bytes; lengths of 0, 1 or above STORE_DEPTH - 2
// drop the block back to header hunting. Checksums are not verified.
// Configuration: i_cfg_we with i_cfg_idx 0 / 1 sets the first / second header
// byte; both reset to zero. Write only while idle.
// Throughput: one input byte per cycle while parsing. On the second checksum
// byte input ready drops; the store is read out through its single read port
// at one byte per cycle unless the output stalls, via the read register into
// the output register. Input ready returns after the last read reaches the
// output register, the emitter then drops busy and the parser leaves its emit
// phase. Stalls hold both; the last byte may still wait as new input is taken.
// Reset (synchronous, active low) returns to header hunting with nothing
// pending; the store contents are left as they are.
module header_length_frame_receiver_core #(
    parameter int STORE_DEPTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [hlfr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  hlfr_pkg::t_byte                    i_cfg_data,
    hlfr_rx_if.sink                            i_rx,
    hlfr_frame_if.source                       o_frame
);

    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int CNT_W  = $clog2(STORE_DEPTH + 1);

    hlfr_pkg::t_byte   r_hdr0;
    hlfr_pkg::t_byte   r_hdr1;
    logic              emit_busy;
    logic              emit_start;
    logic [CNT_W-1:0]  emit_total;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    hlfr_pkg::t_byte   wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
    hlfr_pkg::t_byte   rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr0 <= '0;
            r_hdr1 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                hlfr_pkg::CFG_FIRST_HDR:  r_hdr0 <= i_cfg_data;
                hlfr_pkg::CFG_SECOND_HDR: r_hdr1 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    hlfr_parser #(
        .STORE_DEPTH (STORE_DEPTH),
        .ADDR_W      (ADDR_W),
        .CNT_W       (CNT_W)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_rx.valid),
        .o_ready      (i_rx.ready),
        .i_rx_byte    (i_rx.rx_byte),
        .i_hdr0       (r_hdr0),
        .i_hdr1       (r_hdr1),
        .i_emit_busy  (emit_busy),
        .o_emit_start (emit_start),
        .o_emit_total (emit_total),
        .o_we         (we),
        .o_waddr      (waddr),
        .o_wdata      (wdata)
    );

    hlfr_store #(
        .STORE_DEPTH (STORE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    hlfr_emitter #(
        .STORE_DEPTH (STORE_DEPTH),
        .ADDR_W      (ADDR_W),
        .CNT_W       (CNT_W)
    ) u_emitter (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (emit_start),
        .i_total      (emit_total),
        .o_busy       (emit_busy),
        .o_re         (re),
        .o_raddr      (raddr),
        .i_rdata      (rdata),
        .o_valid      (o_frame.valid),
        .i_ready      (o_frame.ready),
        .o_frame_byte (o_frame.frame_byte),
        .o_frame_last (o_frame.frame_last)
    );

endmodule

### rtl/hlfr_store.sv
module hlfr_store #(
    parameter int STORE_DEPTH = 32,
    parameter int ADDR_W      = $clog2(STORE_DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  hlfr_pkg::t_byte   i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output hlfr_pkg::t_byte   o_rdata
);

    hlfr_pkg::t_byte r_mem [STORE_DEPTH];
    hlfr_pkg::t_byte r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/hlfr_parser.sv
module hlfr_parser #(
    parameter int STORE_DEPTH = 32,
    parameter int ADDR_W      = $clog2(STORE_DEPTH),
    parameter int CNT_W       = $clog2(STORE_DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  hlfr_pkg::t_byte   i_rx_byte,
    input  hlfr_pkg::t_byte   i_hdr0,
    input  hlfr_pkg::t_byte   i_hdr1,
    input  logic              i_emit_busy,
    output logic              o_emit_start,
    output logic [CNT_W-1:0]  o_emit_total,
    output logic              o_we,
    output logic [ADDR_W-1:0] o_waddr,
    output hlfr_pkg::t_byte   o_wdata
);

    localparam hlfr_pkg::t_byte LEN_MAX = hlfr_pkg::BYTE_W'(STORE_DEPTH - 2);

    hlfr_pkg::t_phase r_phase, n_phase;
    logic [CNT_W-1:0] r_wr_idx, n_wr_idx;
    logic [CNT_W-1:0] r_len, n_len;
    logic             accept;
    logic [CNT_W-1:0] wr_idx_inc;

    // no input is taken while the store is being read out
    assign o_ready    = (r_phase != hlfr_pkg::PH_EMIT);
    assign accept     = i_valid && o_ready;
    assign wr_idx_inc = r_wr_idx + CNT_W'(1);
    assign o_wdata    = i_rx_byte;
    assign o_emit_total = wr_idx_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= hlfr_pkg::PH_HEAD0;
            r_wr_idx <= '0;
            r_len    <= '0;
        end else begin
            r_phase  <= n_phase;
            r_wr_idx <= n_wr_idx;
            r_len    <= n_len;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_wr_idx     = r_wr_idx;
        n_len        = r_len;
        o_we         = 1'b0;
        o_waddr      = r_wr_idx[ADDR_W-1:0];
        o_emit_start = 1'b0;
        case (r_phase)
            hlfr_pkg::PH_HEAD0: begin
                if (accept && i_rx_byte == i_hdr0) begin
                    n_phase = hlfr_pkg::PH_HEAD1;
                end
            end
            hlfr_pkg::PH_HEAD1: begin
                if (accept) begin
                    n_wr_idx = '0;
                    n_phase  = (i_rx_byte == i_hdr1) ? hlfr_pkg::PH_LEN : hlfr_pkg::PH_HEAD0;
                end
            end
            hlfr_pkg::PH_LEN: begin
                if (accept) begin
                    if (i_rx_byte > hlfr_pkg::t_byte'(1) && i_rx_byte <= LEN_MAX) begin
                        o_we     = 1'b1;
                        o_waddr  = '0;
                        n_len    = CNT_W'(i_rx_byte);
                        n_wr_idx = CNT_W'(1);
                        n_phase  = hlfr_pkg::PH_PAYL;
                    end else begin
                        n_wr_idx = '0;
                        n_phase  = hlfr_pkg::PH_HEAD0;
                    end
                end
            end
            hlfr_pkg::PH_PAYL: begin
                if (accept) begin
                    o_we     = 1'b1;
                    n_wr_idx = wr_idx_inc;
                    if (wr_idx_inc == r_len) begin
                        n_phase = hlfr_pkg::PH_CSUM0;
                    end
                end
            end
            hlfr_pkg::PH_CSUM0: begin
                if (accept) begin
                    o_we     = 1'b1;
                    n_wr_idx = wr_idx_inc;
                    n_phase  = hlfr_pkg::PH_CSUM1;
                end
            end
            hlfr_pkg::PH_CSUM1: begin
                if (accept) begin
                    o_we         = 1'b1;
                    o_emit_start = 1'b1;
                    n_wr_idx     = wr_idx_inc;
                    n_phase      = hlfr_pkg::PH_EMIT;
                end
            end
            hlfr_pkg::PH_EMIT: begin
                // busy rises the cycle after start, so it is seen high here first
                if (!i_emit_busy) begin
                    n_wr_idx = '0;
                    n_phase  = hlfr_pkg::PH_HEAD0;
                end
            end
            default: begin
                n_wr_idx = '0;
                n_phase  = hlfr_pkg::PH_HEAD0;
            end
        endcase
    end

endmodule

### rtl/hlfr_emitter.sv
module hlfr_emitter #(
    parameter int STORE_DEPTH = 32,
    parameter int ADDR_W      = $clog2(STORE_DEPTH),
    parameter int CNT_W       = $clog2(STORE_DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [CNT_W-1:0]  i_total,
    output logic              o_busy,
    output logic              o_re,
    output logic [ADDR_W-1:0] o_raddr,
    input  hlfr_pkg::t_byte   i_rdata,
    output logic              o_valid,
    input  logic              i_ready,
    output hlfr_pkg::t_byte   o_frame_byte,
    output logic              o_frame_last
);

    logic             r_busy;
    logic [CNT_W-1:0] r_rd_addr;
    logic [CNT_W-1:0] r_total;
    logic             r_pend;
    logic             r_pend_last;
    logic             r_out_valid;
    hlfr_pkg::t_byte  r_out_byte;
    logic             r_out_last;
    logic             remaining;
    logic             load;
    logic             issue;

    assign remaining = r_busy && (r_rd_addr != r_total);
    // memory data waiting in the read register moves on when the output slot frees
    assign load      = r_pend && (!r_out_valid || i_ready);
    assign issue     = remaining && (!r_pend || load);

    assign o_re         = issue;
    assign o_raddr      = r_rd_addr[ADDR_W-1:0];
    assign o_busy       = r_busy;
    assign o_valid      = r_out_valid;
    assign o_frame_byte = r_out_byte;
    assign o_frame_last = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_rd_addr   <= '0;
            r_total     <= '0;
            r_pend      <= 1'b0;
            r_pend_last <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_start) begin
                r_busy    <= 1'b1;
                r_rd_addr <= '0;
                r_total   <= i_total;
            end else if (r_busy && !remaining && !r_pend) begin
                r_busy <= 1'b0;
            end else if (issue) begin
                r_rd_addr <= r_rd_addr + CNT_W'(1);
            end

            if (issue) begin
                r_pend      <= 1'b1;
                r_pend_last <= (r_rd_addr + CNT_W'(1) == r_total);
            end else if (load) begin
                r_pend <= 1'b0;
            end

            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte <= i_rdata;
            r_out_last <= r_pend_last;
        end
    end

endmodule

### rtl/hlfr_checker.sv
module hlfr_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_rx_valid,
    input logic            i_rx_ready,
    input logic            i_frame_valid,
    input logic            i_frame_ready,
    input hlfr_pkg::t_byte i_frame_byte,
    input logic            i_frame_last
);

    // a stalled output transaction holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_frame_valid && !i_frame_ready |=>
            i_frame_valid && $stable(i_frame_byte) && $stable(i_frame_last))
        else $error("output payload changed under stall");

    // mid-frame output means playback is running and input is held off
    a_mid_frame_no_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_frame_valid && !i_frame_last |-> !i_rx_ready)
        else $error("input ready during frame playback");

    // input ready only drops after the byte that completes a frame
    a_ready_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(i_rx_ready) |-> $past(i_rx_valid && i_rx_ready))
        else $error("input ready dropped without a transaction");

    // a new output byte only appears while playback holds input off
    a_out_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_frame_valid) |-> !i_rx_ready)
        else $error("output appeared outside playback");

endmodule

bind header_length_frame_receiver_core hlfr_checker u_hlfr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_rx_valid    (i_rx.valid),
    .i_rx_ready    (i_rx.ready),
    .i_frame_valid (o_frame.valid),
    .i_frame_ready (o_frame.ready),
    .i_frame_byte  (o_frame.frame_byte),
    .i_frame_last  (o_frame.frame_last)
);
